// ===== sv/amtq_pkg.sv =====
// shared types, constants and step functions for the affine matrix to trs block
// depends on nothing; used by the top level, its checker and the testbench
package amtq_pkg;

  // input beat: three basis columns and the translation column, signed q16.16
  typedef struct packed {
    logic signed [31:0] col0_x;
    logic signed [31:0] col0_y;
    logic signed [31:0] col0_z;
    logic signed [31:0] col1_x;
    logic signed [31:0] col1_y;
    logic signed [31:0] col1_z;
    logic signed [31:0] col2_x;
    logic signed [31:0] col2_y;
    logic signed [31:0] col2_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } mat_t;

  // result beat: position q16.16, scale unsigned q16.16, quaternion q2.30
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [31:0] scale_x;
    logic        [31:0] scale_y;
    logic        [31:0] scale_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } trs_t;

  // shepperd branch, one-hot so it doubles as the slot of the main component
  typedef enum logic [3:0] {
    BR_W = 4'b0001,
    BR_X = 4'b0010,
    BR_Y = 4'b0100,
    BR_Z = 4'b1000
  } branch_t;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  // one result bit per stage in every root and quotient unit
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_R_STEPS = 31;
  localparam int DIV_Q_STEPS = 46;
  localparam int DIV_N_STEPS = 31;
  localparam int LAT = 15 + 3 * SQRT_STEPS + DIV_R_STEPS + DIV_Q_STEPS + DIV_N_STEPS;

  // digit-by-digit square root state
  typedef struct packed {
    logic [63:0] v;
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  // restoring divider state
  typedef struct packed {
    logic [63:0] n;
    logic [32:0] rem;
    logic [45:0] quo;
  } div_st_t;

  // one root bit: bring down two radicand bits, try root*4+1
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t    nx;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    rem_sh = {s.rem[33:0], s.v[63:62]};
    trial  = {2'b00, s.root, 2'b01};
    nx.v   = {s.v[61:0], 2'b00};
    if (rem_sh >= trial) begin
      nx.rem  = rem_sh - trial;
      nx.root = {s.root[30:0], 1'b1};
    end else begin
      nx.rem  = rem_sh;
      nx.root = {s.root[30:0], 1'b0};
    end
    return nx;
  endfunction

  // one quotient bit: bring down one dividend bit, subtract if it fits
  function automatic div_st_t div_step(div_st_t s, logic [32:0] d);
    div_st_t     nx;
    logic [33:0] rem_sh;
    logic [33:0] dd;
    logic [33:0] diff;
    rem_sh = {s.rem, s.n[63]};
    dd     = {1'b0, d};
    diff   = rem_sh - dd;
    nx.n   = {s.n[62:0], 1'b0};
    if (rem_sh >= dd) begin
      nx.rem = diff[32:0];
      nx.quo = {s.quo[44:0], 1'b1};
    end else begin
      nx.rem = rem_sh[32:0];
      nx.quo = {s.quo[44:0], 1'b0};
    end
    return nx;
  endfunction

endpackage

// ===== sv/affine_matrix_to_trs_quaternion.sv =====
// affine 3x4 matrix to translation, per-axis scale and unit quaternion
// depends on amtq_pkg (beat types, step functions, stage counts)
//
//  channel  | ports            | handshake
//  ---------+------------------+-------------------------------------------
//  matrix   | mat              | taken at a clock edge with start high, busy low
//  trs      | trs              | valid for one cycle while done is high
//
// fully pipelined: one matrix may enter every cycle. the depth, LAT, is set
// by the three root units and three divider units, each making one bit per
// stage. busy is always low.
// reset clears only the valid bits; payload registers hold no reset.
// the receiver cannot stall, so nothing in the pipeline ever waits.
module affine_matrix_to_trs_quaternion
  import amtq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  mat_t mat,
  output logic done,
  output trs_t trs
);

  typedef struct packed {
    logic [8:0]        neg;
    logic [8:0][31:0]  mag;
    trs_t              o;
  } pa_t;

  typedef struct packed {
    logic [8:0]        neg;
    logic [2:0][31:0]  scale;
    trs_t              o;
  } pb_t;

  typedef struct packed {
    branch_t           br;
    logic [3:0][32:0]  num;
    trs_t              o;
  } pc_t;

  typedef struct packed {
    branch_t           br;
    logic [3:0]        neg;
    logic [30:0]       main;
    logic [32:0]       den;
    trs_t              o;
  } pd_t;

  typedef struct packed {
    logic [3:0]        neg;
    logic [3:0][30:0]  mag;
    trs_t              o;
  } pe_t;

  typedef struct packed {
    logic [3:0]        neg;
    logic [31:0]       n;
    trs_t              o;
  } pf_t;

  // valid bits travel beside the data
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign busy = 1'b0;
  assign done = vld[LAT-1];

  // input register
  mat_t s0_m;

  always_ff @(posedge clk) begin
    s0_m <= mat;
  end

  // elements in column-major order, translation into the carried result
  logic signed [8:0][31:0] s0_e;
  trs_t                    s0_o;

  always_comb begin
    s0_e[0] = s0_m.col0_x;
    s0_e[1] = s0_m.col0_y;
    s0_e[2] = s0_m.col0_z;
    s0_e[3] = s0_m.col1_x;
    s0_e[4] = s0_m.col1_y;
    s0_e[5] = s0_m.col1_z;
    s0_e[6] = s0_m.col2_x;
    s0_e[7] = s0_m.col2_y;
    s0_e[8] = s0_m.col2_z;
    s0_o       = '0;
    s0_o.pos_x = s0_m.trans_x;
    s0_o.pos_y = s0_m.trans_y;
    s0_o.pos_z = s0_m.trans_z;
  end

  // sign and magnitude
  pa_t s1_p;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      s1_p.neg[k] <= s0_e[k][31];
      s1_p.mag[k] <= s0_e[k][31] ? (~s0_e[k] + 32'd1) : s0_e[k];
    end
    s1_p.o <= s0_o;
  end

  // squares
  logic [8:0][63:0] s2_sq;
  pa_t              s2_p;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      s2_sq[k] <= 64'(s1_p.mag[k]) * 64'(s1_p.mag[k]);
    end
    s2_p <= s1_p;
  end

  // column length roots
  sqrt_st_t sa   [SQRT_STEPS+1][3];
  pa_t      sa_p [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sa[0][j].v    <= s2_sq[3*j] + s2_sq[3*j+1] + s2_sq[3*j+2];
      sa[0][j].rem  <= '0;
      sa[0][j].root <= '0;
    end
    sa_p[0] <= s2_p;
    for (int t = 0; t < SQRT_STEPS; t++) begin
      for (int j = 0; j < 3; j++) begin
        sa[t+1][j] <= sqrt_step(sa[t][j]);
      end
      sa_p[t+1] <= sa_p[t];
    end
  end

  // carried result with the column lengths filled in
  trs_t da_o;

  always_comb begin
    da_o         = sa_p[SQRT_STEPS].o;
    da_o.scale_x = sa[SQRT_STEPS][0].root;
    da_o.scale_y = sa[SQRT_STEPS][1].root;
    da_o.scale_z = sa[SQRT_STEPS][2].root;
  end

  // unit column dividers, element times 2^30 over its column length
  div_st_t da   [DIV_R_STEPS+1][9];
  pb_t     da_p [DIV_R_STEPS+1];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        da[0][3*j+i].rem <= {2'b00, sa_p[SQRT_STEPS].mag[3*j+i][31:1]};
        da[0][3*j+i].n   <= {sa_p[SQRT_STEPS].mag[3*j+i][0], 30'b0, 33'b0};
        da[0][3*j+i].quo <= '0;
      end
      da_p[0].scale[j] <= sa[SQRT_STEPS][j].root;
    end
    da_p[0].neg <= sa_p[SQRT_STEPS].neg;
    da_p[0].o   <= da_o;
    for (int t = 0; t < DIV_R_STEPS; t++) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          da[t+1][3*j+i] <= div_step(da[t][3*j+i], {1'b0, da_p[t].scale[j]});
        end
      end
      da_p[t+1] <= da_p[t];
    end
  end

  // rotation matrix, zero columns become the canonical axis
  logic signed [31:0] r [3][3];
  trs_t               r_o;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (da_p[DIV_R_STEPS].scale[j] == 32'd0) begin
          r[i][j] <= (i == j) ? Q30_ONE : 32'sd0;
        end else if (da_p[DIV_R_STEPS].neg[3*j+i]) begin
          r[i][j] <= -$signed({1'b0, da[DIV_R_STEPS][3*j+i].quo[30:0]});
        end else begin
          r[i][j] <= $signed({1'b0, da[DIV_R_STEPS][3*j+i].quo[30:0]});
        end
      end
    end
    r_o <= da_p[DIV_R_STEPS].o;
  end

  // trace, branch radicands, off-diagonal sums and differences
  logic signed [33:0] t1_trace;
  logic signed [33:0] t1_rad [4];
  logic signed [32:0] t1_d21, t1_d02, t1_d10, t1_s01, t1_s02, t1_s12;
  logic               t1_g01, t1_g02, t1_g12;
  trs_t               t1_o;

  always_ff @(posedge clk) begin
    t1_trace  <= 34'(r[0][0]) + 34'(r[1][1]) + 34'(r[2][2]);
    t1_rad[0] <= 34'(r[0][0]) + 34'(r[1][1]) + 34'(r[2][2]) + 34'(Q30_ONE);
    t1_rad[1] <= 34'(Q30_ONE) + 34'(r[0][0]) - 34'(r[1][1]) - 34'(r[2][2]);
    t1_rad[2] <= 34'(Q30_ONE) + 34'(r[1][1]) - 34'(r[0][0]) - 34'(r[2][2]);
    t1_rad[3] <= 34'(Q30_ONE) + 34'(r[2][2]) - 34'(r[0][0]) - 34'(r[1][1]);
    t1_d21    <= 33'(r[2][1]) - 33'(r[1][2]);
    t1_d02    <= 33'(r[0][2]) - 33'(r[2][0]);
    t1_d10    <= 33'(r[1][0]) - 33'(r[0][1]);
    t1_s01    <= 33'(r[0][1]) + 33'(r[1][0]);
    t1_s02    <= 33'(r[0][2]) + 33'(r[2][0]);
    t1_s12    <= 33'(r[1][2]) + 33'(r[2][1]);
    t1_g01    <= r[0][0] > r[1][1];
    t1_g02    <= r[0][0] > r[2][2];
    t1_g12    <= r[1][1] > r[2][2];
    t1_o      <= r_o;
  end

  // branch choice, clamped radicand and numerators
  branch_t            t2_br;
  logic signed [33:0] t2_rad;
  logic        [32:0] t2_rad_u;
  logic [3:0][32:0]   t2_num;

  always_comb begin
    priority if (t1_trace > 34'sd0) begin
      t2_br = BR_W;
    end else if (t1_g01 && t1_g02) begin
      t2_br = BR_X;
    end else if (t1_g12) begin
      t2_br = BR_Y;
    end else begin
      t2_br = BR_Z;
    end
    unique case (t2_br)
      BR_W: begin
        t2_rad = t1_rad[0];
        t2_num = {t1_d10, t1_d02, t1_d21, 33'd0};
      end
      BR_X: begin
        t2_rad = t1_rad[1];
        t2_num = {t1_s02, t1_s01, 33'd0, t1_d21};
      end
      BR_Y: begin
        t2_rad = t1_rad[2];
        t2_num = {t1_s12, 33'd0, t1_s01, t1_d02};
      end
      BR_Z: begin
        t2_rad = t1_rad[3];
        t2_num = {33'd0, t1_s12, t1_s02, t1_d10};
      end
      default: begin
        t2_rad = '0;
        t2_num = '0;
      end
    endcase
    t2_rad_u = t2_rad[33] ? 33'd0 : t2_rad[32:0];
  end

  // branch roots
  sqrt_st_t sb   [SQRT_STEPS+1];
  pc_t      sb_p [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    sb[0].v       <= {1'b0, t2_rad_u, 30'b0};
    sb[0].rem     <= '0;
    sb[0].root    <= '0;
    sb_p[0].br    <= t2_br;
    sb_p[0].num   <= t2_num;
    sb_p[0].o     <= t1_o;
    for (int t = 0; t < SQRT_STEPS; t++) begin
      sb[t+1]   <= sqrt_step(sb[t]);
      sb_p[t+1] <= sb_p[t];
    end
  end

  // numerator magnitudes for the component dividers
  logic [3:0][32:0] d0_mag;

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      d0_mag[s] = sb_p[SQRT_STEPS].num[s][32] ? (~sb_p[SQRT_STEPS].num[s] + 33'd1)
                                              : sb_p[SQRT_STEPS].num[s];
    end
  end

  // component dividers, numerator (difference or sum) times 2^30 over twice the root
  div_st_t db   [DIV_Q_STEPS+1][4];
  pd_t     db_p [DIV_Q_STEPS+1];

  always_ff @(posedge clk) begin
    for (int s = 0; s < 4; s++) begin
      db[0][s].rem    <= {15'b0, 2'b00, d0_mag[s][31:16]};
      db[0][s].n      <= {d0_mag[s][15:0], 30'b0, 18'b0};
      db[0][s].quo    <= '0;
      db_p[0].neg[s]  <= sb_p[SQRT_STEPS].num[s][32];
    end
    db_p[0].br   <= sb_p[SQRT_STEPS].br;
    db_p[0].main <= sb[SQRT_STEPS].root[31:1];
    db_p[0].den  <= {sb[SQRT_STEPS].root, 1'b0};
    db_p[0].o    <= sb_p[SQRT_STEPS].o;
    for (int t = 0; t < DIV_Q_STEPS; t++) begin
      for (int s = 0; s < 4; s++) begin
        db[t+1][s] <= div_step(db[t][s], db_p[t].den);
      end
      db_p[t+1] <= db_p[t];
    end
  end

  // assemble the raw quaternion as sign and magnitude
  logic [3:0][45:0] n1_qm;
  logic [3:0]       n1_neg;
  logic [45:0]      n1_or;
  trs_t             n1_o;
  logic [3:0][45:0] n1_qm_c;
  logic [3:0]       n1_neg_c;
  logic [3:0]       n1_sel;

  always_comb begin
    n1_sel = db_p[DIV_Q_STEPS].br;
    for (int s = 0; s < 4; s++) begin
      if (n1_sel[s]) begin
        n1_qm_c[s]  = {15'b0, db_p[DIV_Q_STEPS].main};
        n1_neg_c[s] = 1'b0;
      end else if (db_p[DIV_Q_STEPS].den == 33'd0) begin
        n1_qm_c[s]  = '0;
        n1_neg_c[s] = 1'b0;
      end else begin
        n1_qm_c[s]  = db[DIV_Q_STEPS][s].quo;
        n1_neg_c[s] = db_p[DIV_Q_STEPS].neg[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    n1_qm  <= n1_qm_c;
    n1_neg <= n1_neg_c;
    n1_or  <= n1_qm_c[0] | n1_qm_c[1] | n1_qm_c[2] | n1_qm_c[3];
    n1_o   <= db_p[DIV_Q_STEPS].o;
  end

  // bring the largest magnitude below 2^31
  logic [3:0]       n2_k;
  logic [3:0][45:0] n2_sh;
  logic [3:0][30:0] n2_mag;
  logic [3:0]       n2_neg;
  trs_t             n2_o;

  always_comb begin
    n2_k = '0;
    for (int b = 31; b < 46; b++) begin
      if (n1_or[b]) begin
        n2_k = 4'(b - 30);
      end
    end
    for (int s = 0; s < 4; s++) begin
      n2_sh[s] = n1_qm[s] >> n2_k;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < 4; s++) begin
      n2_mag[s] <= n2_sh[s][30:0];
    end
    n2_neg <= n1_neg;
    n2_o   <= n1_o;
  end

  // squares for the norm
  logic [3:0][61:0] n3_sq;
  pe_t              n3_p;

  always_ff @(posedge clk) begin
    for (int s = 0; s < 4; s++) begin
      n3_sq[s] <= 62'(n2_mag[s]) * 62'(n2_mag[s]);
    end
    n3_p.neg <= n2_neg;
    n3_p.mag <= n2_mag;
    n3_p.o   <= n2_o;
  end

  // norm root
  sqrt_st_t sc   [SQRT_STEPS+1];
  pe_t      sc_p [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    sc[0].v    <= 64'(n3_sq[0]) + 64'(n3_sq[1]) + 64'(n3_sq[2]) + 64'(n3_sq[3]);
    sc[0].rem  <= '0;
    sc[0].root <= '0;
    sc_p[0]    <= n3_p;
    for (int t = 0; t < SQRT_STEPS; t++) begin
      sc[t+1]   <= sqrt_step(sc[t]);
      sc_p[t+1] <= sc_p[t];
    end
  end

  // normalizing dividers, component times 2^30 over the norm
  div_st_t dc   [DIV_N_STEPS+1][4];
  pf_t     dc_p [DIV_N_STEPS+1];

  always_ff @(posedge clk) begin
    for (int s = 0; s < 4; s++) begin
      dc[0][s].rem <= {3'b000, sc_p[SQRT_STEPS].mag[s][30:1]};
      dc[0][s].n   <= {sc_p[SQRT_STEPS].mag[s][0], 63'b0};
      dc[0][s].quo <= '0;
    end
    dc_p[0].neg <= sc_p[SQRT_STEPS].neg;
    dc_p[0].n   <= sc[SQRT_STEPS].root;
    dc_p[0].o   <= sc_p[SQRT_STEPS].o;
    for (int t = 0; t < DIV_N_STEPS; t++) begin
      for (int s = 0; s < 4; s++) begin
        dc[t+1][s] <= div_step(dc[t][s], {1'b0, dc_p[t].n});
      end
      dc_p[t+1] <= dc_p[t];
    end
  end

  // result register, zero norm gives the identity
  logic signed [3:0][31:0] q_out;
  trs_t                    q_trs;

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      if (dc_p[DIV_N_STEPS].n == 32'd0) begin
        q_out[s] = (s == 0) ? Q30_ONE : 32'sd0;
      end else if (dc_p[DIV_N_STEPS].neg[s]) begin
        q_out[s] = -$signed({1'b0, dc[DIV_N_STEPS][s].quo[30:0]});
      end else begin
        q_out[s] = $signed({1'b0, dc[DIV_N_STEPS][s].quo[30:0]});
      end
    end
    q_trs        = dc_p[DIV_N_STEPS].o;
    q_trs.quat_w = q_out[0];
    q_trs.quat_x = q_out[1];
    q_trs.quat_y = q_out[2];
    q_trs.quat_z = q_out[3];
  end

  always_ff @(posedge clk) begin
    trs <= q_trs;
  end

endmodule

// ===== sv/amtq_check.sv =====
// port-level checks for the affine matrix to trs block, bound to its top level
// depends on amtq_pkg (beat types, pipeline latency)
module amtq_check
  import amtq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input mat_t mat,
  input logic done,
  input trs_t trs
);

  // every accepted beat comes out after the fixed latency
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted beat did not complete");

  // no result without an accepted beat
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LAT !done)
    else $error("result without input beat");

  // translation x and z pass through untouched
  a_pos: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT (trs.pos_x == $past(mat.trans_x, LAT) &&
                                trs.pos_z == $past(mat.trans_z, LAT)))
    else $error("position mismatch");

  // all-zero first column has zero scale_x
  a_zero_col: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mat.col0_x == 32'sd0 && mat.col0_y == 32'sd0 &&
     mat.col0_z == 32'sd0) |-> ##LAT (trs.scale_x == 32'd0))
    else $error("zero column scale");

  // unit quaternion components stay within one
  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (trs.quat_w <= Q30_ONE && trs.quat_w >= -Q30_ONE &&
              trs.quat_x <= Q30_ONE && trs.quat_x >= -Q30_ONE &&
              trs.quat_y <= Q30_ONE && trs.quat_y >= -Q30_ONE &&
              trs.quat_z <= Q30_ONE && trs.quat_z >= -Q30_ONE))
    else $error("quaternion component out of range");

endmodule

bind affine_matrix_to_trs_quaternion amtq_check u_amtq_check (.*);

// ===== tb/affine_matrix_to_trs_quaternion_tb.sv =====
// testbench for affine_matrix_to_trs_quaternion: directed table then random matrices
// depends on amtq_pkg and the block; predicts each result beat with its own integer model
`timescale 1ns / 100ps

module affine_matrix_to_trs_quaternion_tb;
  import amtq_pkg::*;

  localparam int DRAIN_CYCLES = LAT + 20;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 1630;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  mat_t mat = '0;
  logic busy;
  logic done;
  trs_t trs;

  affine_matrix_to_trs_quaternion dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mat(mat), .done(done), .trs(trs)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  trs_t pending_trs[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  longint cycles = 0;
  int idle_pct = 0;

  // mismatch report: one line, one count
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("ERROR beat %0d %s: got %h want %h", beats_out, what, got, want);
  endtask

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // trunc(a * 2^30 / d), zero on zero divisor
  function automatic longint qdiv(input longint a, input logic [63:0] d);
    logic [63:0] m;
    if (d == 0) return 0;
    m = (mag(a) << 30) / d;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] broot(input longint rad);
    if (rad < 0) rad = 0;
    return root64(64'(rad) << 30);
  endfunction

  // decompose one matrix into translation, scale and rotation
  function automatic trs_t decompose(input mat_t m);
    trs_t o;
    longint c[3][3];
    longint r[3][3];
    logic [63:0] sc[3];
    longint q[4];
    longint tr;
    logic [63:0] rt, den, maxm, sum, n, mm;
    int k;
    c[0][0] = m.col0_x; c[0][1] = m.col0_y; c[0][2] = m.col0_z;
    c[1][0] = m.col1_x; c[1][1] = m.col1_y; c[1][2] = m.col1_z;
    c[2][0] = m.col2_x; c[2][1] = m.col2_y; c[2][2] = m.col2_z;
    for (int j = 0; j < 3; j++) begin
      sum = 0;
      for (int i = 0; i < 3; i++) sum += mag(c[j][i]) * mag(c[j][i]);
      sc[j] = root64(sum);
      if (sc[j] > 64'hFFFF_FFFF) sc[j] = 64'hFFFF_FFFF;
      for (int i = 0; i < 3; i++)
        r[i][j] = (sum == 0) ? ((i == j) ? longint'(ONE_Q30) : 0) : qdiv(c[j][i], sc[j]);
    end
    tr = r[0][0] + r[1][1] + r[2][2];
    // shepperd branch selection, strict comparisons
    if (tr > 0) begin
      rt = broot(tr + longint'(ONE_Q30)); den = 2 * rt;
      q[0] = longint'(rt >> 1);
      q[1] = qdiv(r[2][1] - r[1][2], den);
      q[2] = qdiv(r[0][2] - r[2][0], den);
      q[3] = qdiv(r[1][0] - r[0][1], den);
    end else if (r[0][0] > r[1][1] && r[0][0] > r[2][2]) begin
      rt = broot(longint'(ONE_Q30) + r[0][0] - r[1][1] - r[2][2]); den = 2 * rt;
      q[0] = qdiv(r[2][1] - r[1][2], den);
      q[1] = longint'(rt >> 1);
      q[2] = qdiv(r[0][1] + r[1][0], den);
      q[3] = qdiv(r[0][2] + r[2][0], den);
    end else if (r[1][1] > r[2][2]) begin
      rt = broot(longint'(ONE_Q30) + r[1][1] - r[0][0] - r[2][2]); den = 2 * rt;
      q[0] = qdiv(r[0][2] - r[2][0], den);
      q[1] = qdiv(r[0][1] + r[1][0], den);
      q[2] = longint'(rt >> 1);
      q[3] = qdiv(r[1][2] + r[2][1], den);
    end else begin
      rt = broot(longint'(ONE_Q30) + r[2][2] - r[0][0] - r[1][1]); den = 2 * rt;
      q[0] = qdiv(r[1][0] - r[0][1], den);
      q[1] = qdiv(r[0][2] + r[2][0], den);
      q[2] = qdiv(r[1][2] + r[2][1], den);
      q[3] = longint'(rt >> 1);
    end
    // normalize, pre-shifting so the squares fit
    maxm = 0;
    for (int i = 0; i < 4; i++) if (mag(q[i]) > maxm) maxm = mag(q[i]);
    k = 0;
    while (k < 63 && (maxm >> k) >= (64'd1 << 31)) k++;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mm = mag(q[i]) >> k;
      q[i] = q[i] < 0 ? -longint'(mm) : longint'(mm);
      sum += mm * mm;
    end
    n = root64(sum);
    if (n == 0) begin
      q[0] = longint'(ONE_Q30); q[1] = 0; q[2] = 0; q[3] = 0;
    end else begin
      for (int i = 0; i < 4; i++) q[i] = qdiv(q[i], n);
    end
    o.pos_x = m.trans_x; o.pos_y = m.trans_y; o.pos_z = m.trans_z;
    o.scale_x = sc[0][31:0]; o.scale_y = sc[1][31:0]; o.scale_z = sc[2][31:0];
    o.quat_w = q[0][31:0]; o.quat_x = q[1][31:0];
    o.quat_y = q[2][31:0]; o.quat_z = q[3][31:0];
    return o;
  endfunction

  // directed rows; known results typed in where obvious
  typedef struct {
    mat_t m;
    bit   typed;
    trs_t want;
  } row_t;
  row_t rows[$];

  function automatic mat_t diag(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c);
    mat_t m;
    m = '0;
    m.col0_x = a; m.col1_y = b; m.col2_z = c;
    return m;
  endfunction

  function automatic logic [31:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'(int'($urandom_range(0, 131072)) - 65536);
      default: return $urandom();
    endcase
  endfunction

  // mostly random elements shifted down by a random amount, else edge-case elements
  function automatic mat_t rnd_mat();
    mat_t m;
    logic [31:0] e[9];
    int s;
    for (int i = 0; i < 9; i++) e[i] = rnd_elem();
    if ($urandom_range(0, 3) != 0) begin
      s = $urandom_range(1, 12);
      for (int i = 0; i < 9; i++) e[i] = 32'($signed($urandom()) >>> s);
      if ($urandom_range(0, 5) == 0) e[$urandom_range(0, 2) * 4] = 0;
      if ($urandom_range(0, 7) == 0) begin
        s = $urandom_range(0, 2) * 3;
        e[s] = 0; e[s + 1] = 0; e[s + 2] = 0;
      end
    end
    m.col0_x = e[0]; m.col0_y = e[1]; m.col0_z = e[2];
    m.col1_x = e[3]; m.col1_y = e[4]; m.col1_z = e[5];
    m.col2_x = e[6]; m.col2_y = e[7]; m.col2_z = e[8];
    m.trans_x = $urandom(); m.trans_y = $urandom(); m.trans_z = $urandom();
    return m;
  endfunction

  task automatic add_row(input mat_t m, input bit typed, input trs_t want);
    row_t rw;
    rw.m = m; rw.typed = typed; rw.want = want;
    rows.push_back(rw);
  endtask

  task automatic build_rows();
    trs_t w;
    mat_t m;
    // all zero: identity rotation, zero scale
    w = '0; w.quat_w = Q30_ONE;
    add_row('0, 1, w);
    // unit diagonal with extreme translation
    m = diag(32'h1_0000, 32'h1_0000, 32'h1_0000);
    m.trans_x = 32'h8000_0000; m.trans_y = 32'h7FFF_FFFF; m.trans_z = 32'hFFFF_FFFF;
    w = '0; w.pos_x = m.trans_x; w.pos_y = m.trans_y; w.pos_z = m.trans_z;
    w.scale_x = 32'h1_0000; w.scale_y = 32'h1_0000; w.scale_z = 32'h1_0000;
    w.quat_w = Q30_ONE;
    add_row(m, 1, w);
    // each shepperd branch and ties
    add_row(diag(32'h1_0000, 32'hFFFF_0000, 32'hFFFF_0000), 0, w);
    add_row(diag(32'hFFFF_0000, 32'h1_0000, 32'hFFFF_0000), 0, w);
    add_row(diag(32'hFFFF_0000, 32'hFFFF_0000, 32'h1_0000), 0, w);
    add_row(diag(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000), 0, w);
    add_row(diag(32'h1_0000, 32'h1_0000, 32'hFFFF_0000), 0, w);
    // extremes: most negative, most positive, minus one lsb and one lsb everywhere
    m = '1; m = {12{32'h8000_0000}}; add_row(m, 0, w);
    m = {12{32'h7FFF_FFFF}}; add_row(m, 0, w);
    m = {12{32'hFFFF_FFFF}}; add_row(m, 0, w);
    m = {12{32'h0000_0001}}; add_row(m, 0, w);
    // single zero column in each slot
    m = {12{32'h0001_2345}}; m.col0_x = 0; m.col0_y = 0; m.col0_z = 0; add_row(m, 0, w);
    m = {12{32'hFFF1_2345}}; m.col1_x = 0; m.col1_y = 0; m.col1_z = 0; add_row(m, 0, w);
    m = {12{32'h0801_0000}}; m.col2_x = 0; m.col2_y = 0; m.col2_z = 0; add_row(m, 0, w);
    // 90 degree rotation about z, and a sheared matrix
    m = '0; m.col0_y = 32'h1_0000; m.col1_x = 32'hFFFF_0000; m.col2_z = 32'h1_0000;
    add_row(m, 0, w);
    m = diag(32'h1_0000, 32'h1_0000, 32'h1_0000); m.col1_x = 32'h8000; add_row(m, 0, w);
    // alternating bit patterns
    m = {12{32'hAAAA_AAAA}}; add_row(m, 0, w);
    m = {12{32'h5555_5555}}; add_row(m, 0, w);
  endtask

  // send one matrix, with random idle cycles before it
  task automatic send(input mat_t m);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mat <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_trs.push_back(decompose(m));
    beats_in++;
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_trs.size() == 0) begin
        report("unexpected beat", trs.pos_x, 32'h0);
      end else begin
        trs_t w;
        w = pending_trs.pop_front();
        if (trs.pos_x !== w.pos_x) report("pos_x", trs.pos_x, w.pos_x);
        if (trs.pos_y !== w.pos_y) report("pos_y", trs.pos_y, w.pos_y);
        if (trs.pos_z !== w.pos_z) report("pos_z", trs.pos_z, w.pos_z);
        if (trs.scale_x !== w.scale_x) report("scale_x", trs.scale_x, w.scale_x);
        if (trs.scale_y !== w.scale_y) report("scale_y", trs.scale_y, w.scale_y);
        if (trs.scale_z !== w.scale_z) report("scale_z", trs.scale_z, w.scale_z);
        if (trs.quat_w !== w.quat_w) report("quat_w", trs.quat_w, w.quat_w);
        if (trs.quat_x !== w.quat_x) report("quat_x", trs.quat_x, w.quat_x);
        if (trs.quat_y !== w.quat_y) report("quat_y", trs.quat_y, w.quat_y);
        if (trs.quat_z !== w.quat_z) report("quat_z", trs.quat_z, w.quat_z);
      end
      beats_out++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("affine_matrix_to_trs_quaternion: mismatch");
      $finish;
    end
  end

  // stimulus
  initial begin
    int wait_cycles;
    build_rows();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed table; typed rows cross-checked against the predictor
    idle_pct = 30;
    foreach (rows[i]) begin
      if (rows[i].typed && decompose(rows[i].m) !== rows[i].want) begin
        errors++;
        $display("ERROR directed row %0d: predictor disagrees with typed result", i);
      end
      send(rows[i].m);
    end
    // random: sender idles often, then more often, then never
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_pct = (i < N_RANDOM / 3) ? 30 : (i < 2 * N_RANDOM / 3) ? 46 : 0;
      if (i % 97 == 50) idle_pct = 0;
      send(rnd_mat());
    end
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_trs.size() != 0 && wait_cycles < 4 * DRAIN_CYCLES) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_trs.size() != 0) begin
      errors++;
      $display("ERROR %0d result beats never arrived", pending_trs.size());
    end
    $display("sent %0d matrices (directed branches, zero columns, extremes, random)",
             beats_in);
    $display("checked %0d result beats, %0d field errors", beats_out, errors);
    if (errors == 0) begin
      $display("affine_matrix_to_trs_quaternion: match");
    end else begin
      $display("affine_matrix_to_trs_quaternion: mismatch");
    end
    $finish;
  end

endmodule
